/* design/swfm_pkg.sv */
// Shared types and constants for the supply window fault monitor.
package swfm_pkg;

    localparam int unsigned UNIT_COUNT = 4;
    localparam int unsigned UNIT_IDX_W = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_VOLT_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_VOLT_UPPER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_VOLT_HYST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOWER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_UPPER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL24_MIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL5_MIN       = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_LINE_VOLT_LOWER = 16'd241;
    localparam logic [15:0] RST_LINE_VOLT_UPPER = 16'd364;
    localparam logic [15:0] RST_LINE_VOLT_HYST  = 16'd14;
    localparam logic [15:0] RST_FREQ_LOWER      = 16'd95;
    localparam logic [15:0] RST_FREQ_UPPER      = 16'd105;
    localparam logic [15:0] RST_RAIL24_MIN      = 16'd20;
    localparam logic [15:0] RST_RAIL5_MIN       = 16'd4;

    // rail release margin above the minimum
    localparam logic [15:0] RAIL_MARGIN = 16'd2;

    // fault codes
    localparam logic [2:0] FAULT_VOLT_LOW  = 3'd0;
    localparam logic [2:0] FAULT_VOLT_HIGH = 3'd1;
    localparam logic [2:0] FAULT_FREQ_LOW  = 3'd2;
    localparam logic [2:0] FAULT_FREQ_HIGH = 3'd3;
    localparam logic [2:0] FAULT_RAIL24    = 3'd4;
    localparam logic [2:0] FAULT_RAIL5     = 3'd5;

    typedef struct packed {
        logic [3:0]  unit;
        logic        alive;
        logic [15:0] line_volt;
        logic [15:0] line_freq;
        logic [15:0] rail24_a;
        logic [15:0] rail24_b;
        logic [15:0] rail5_a;
        logic [15:0] rail5_b;
        logic [31:0] stamp;
    } telemetry_t;

    typedef struct packed {
        logic [2:0]  fault_code;
        logic [3:0]  fault_unit;
        logic [31:0] fault_stamp;
        logic [31:0] fault_param;
        logic        last_event;
    } fault_event_t;

    // per-unit fault latches, one memory word
    typedef struct packed {
        logic volt;
        logic freq;
        logic rail24;
        logic rail5;
    } latch_t;

endpackage

/* design/supply_window_fault_monitor.sv */
// Top level of the supply window fault monitor: latch memory, check stage, event serializer.
//
// Checks one telemetry transfer per supply unit tick against line voltage and
// frequency windows (with release hysteresis) and the 24 V / 5 V rail minimums,
// and emits up to four fault events per transfer, in the order line voltage,
// frequency, 24 V rail, 5 V rail; last_event marks the final one of a transfer.
// The four fault latches of each unit live in one small synchronous memory
// (one word per unit). A transfer is read from that memory at acceptance, checked
// in the next cycle and written back as it moves into the event buffer; a
// write that lands on the same unit as the read of the following transfer is
// bypassed into it. A transfer moves from the check stage into the event buffer
// once the buffer has no event left to load, and each event goes into the output
// register when that is free. The single output register drains one event per
// cycle while the receiver does not stall, so transfers raising at most one event
// are then taken every cycle, and a transfer raising more holds the next one
// back until its last event is loaded. Latch valid bits clear at reset,
// so the block is ready right after reset with no clearing pass. Telemetry for a
// unit that is not alive, or whose index is not below UNIT_COUNT, raises nothing
// and leaves the latches alone. Configuration writes are taken every cycle
// (cfg_ready is held high) and must only be issued while the block is idle.
module supply_window_fault_monitor
    import swfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  tlm_valid,
    output logic                  tlm_stall,
    input  telemetry_t            tlm,

    output logic                  evt_valid,
    input  logic                  evt_stall,
    output fault_event_t          evt,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] volt_lower_reg, volt_upper_reg, volt_hyst_reg;
    logic [15:0] freq_lower_reg, freq_upper_reg;
    logic [15:0] rail24_min_reg, rail5_min_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_lower_reg <= RST_LINE_VOLT_LOWER;
            volt_upper_reg <= RST_LINE_VOLT_UPPER;
            volt_hyst_reg  <= RST_LINE_VOLT_HYST;
            freq_lower_reg <= RST_FREQ_LOWER;
            freq_upper_reg <= RST_FREQ_UPPER;
            rail24_min_reg <= RST_RAIL24_MIN;
            rail5_min_reg  <= RST_RAIL5_MIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINE_VOLT_LOWER: volt_lower_reg <= cfg_data;
                CFG_LINE_VOLT_UPPER: volt_upper_reg <= cfg_data;
                CFG_LINE_VOLT_HYST:  volt_hyst_reg  <= cfg_data;
                CFG_FREQ_LOWER:      freq_lower_reg <= cfg_data;
                CFG_FREQ_UPPER:      freq_upper_reg <= cfg_data;
                CFG_RAIL24_MIN:      rail24_min_reg <= cfg_data;
                CFG_RAIL5_MIN:       rail5_min_reg  <= cfg_data;
                default:             ; // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    telemetry_t            s1_item_reg;
    logic                  s1_adv;
    logic                  s1_active;
    logic                  tlm_accept;

    logic [3:0]            buf_mask_reg;
    logic [3:0]            buf_mask_next;
    telemetry_t            buf_item_reg;
    logic [2:0]            buf_volt_code_reg;
    logic [2:0]            buf_freq_code_reg;

    logic                  out_free;
    logic                  evt_load;
    logic [3:0]            pick;
    logic [3:0]            remain;
    logic                  buf_done;

    logic                  evt_valid_reg;
    fault_event_t          evt_reg;
    fault_event_t          evt_next;

    assign out_free   = !evt_valid_reg || !evt_stall;
    assign evt_load   = (buf_mask_reg != 4'b0000) && out_free;
    assign pick       = buf_mask_reg & (~buf_mask_reg + 4'd1);   // lowest pending event
    assign remain     = buf_mask_reg & ~pick;
    assign buf_done   = (buf_mask_reg == 4'b0000) || (evt_load && (remain == 4'b0000));
    assign s1_adv     = s1_valid_reg && buf_done;
    assign tlm_stall  = s1_valid_reg && !s1_adv;
    assign tlm_accept = tlm_valid && !tlm_stall;

    // ------------------------------------------------------------------
    // Latch memory: one word per unit, read on transfer, written back on advance
    // ------------------------------------------------------------------
    latch_t                lat_mem [UNIT_COUNT];
    logic [UNIT_COUNT-1:0] lat_vld_reg;
    latch_t                rd_data_reg;
    logic                  rd_vld_reg;
    logic                  fwd_reg;
    latch_t                fwd_data_reg;

    logic [UNIT_IDX_W-1:0] rd_addr;
    logic [UNIT_IDX_W-1:0] wr_addr;
    logic                  wr_en;
    latch_t                wr_data;
    latch_t                cur;

    assign rd_addr = tlm.unit[UNIT_IDX_W-1:0];
    assign wr_addr = s1_item_reg.unit[UNIT_IDX_W-1:0];
    assign wr_en   = s1_adv && s1_active;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lat_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tlm_accept)
        begin
            rd_data_reg  <= lat_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                lat_vld_reg[wr_addr] <= 1'b1;
            end
            if (tlm_accept)
            begin
                rd_vld_reg <= lat_vld_reg[rd_addr];
                // same-unit write at this edge is not yet visible in the read
                fwd_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // bypass first, then memory; never-written units read as clear
    always_comb
    begin
        if (fwd_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // Check stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tlm_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tlm_accept)
        begin
            s1_item_reg <= tlm;
        end
    end

    assign s1_active = s1_item_reg.alive &&
                       ({1'b0, s1_item_reg.unit} < 5'(UNIT_COUNT));

    logic [15:0] volt_rel_lo, volt_rel_hi;
    logic [15:0] r24_rel, r5_rel;
    logic        volt_lo_hit, volt_hi_hit, volt_release;
    logic        freq_lo_hit, freq_hi_hit, freq_release;
    logic        r24_fire, r24_release;
    logic        r5_fire, r5_release;
    logic [3:0]  ev_mask;

    always_comb
    begin
        volt_rel_lo = volt_lower_reg + volt_hyst_reg;
        volt_rel_hi = volt_upper_reg - volt_hyst_reg;
        r24_rel     = rail24_min_reg + RAIL_MARGIN;
        r5_rel      = rail5_min_reg + RAIL_MARGIN;

        // line voltage window
        volt_lo_hit  = !cur.volt && (volt_lower_reg != 16'd0) &&
                       (s1_item_reg.line_volt < volt_lower_reg);
        volt_hi_hit  = !cur.volt && !volt_lo_hit && (volt_upper_reg != 16'd0) &&
                       (s1_item_reg.line_volt > volt_upper_reg);
        volt_release = (s1_item_reg.line_volt >= volt_rel_lo) &&
                       (s1_item_reg.line_volt <= volt_rel_hi);

        // frequency window, no hysteresis
        freq_lo_hit  = !cur.freq && (freq_lower_reg != 16'd0) &&
                       (s1_item_reg.line_freq < freq_lower_reg);
        freq_hi_hit  = !cur.freq && !freq_lo_hit && (freq_upper_reg != 16'd0) &&
                       (s1_item_reg.line_freq > freq_upper_reg);
        freq_release = (s1_item_reg.line_freq >= freq_lower_reg) &&
                       (s1_item_reg.line_freq <= freq_upper_reg);

        // rails
        r24_fire    = (rail24_min_reg != 16'd0) && !cur.rail24 &&
                      ((s1_item_reg.rail24_a < rail24_min_reg) ||
                       (s1_item_reg.rail24_b < rail24_min_reg));
        r24_release = (s1_item_reg.rail24_a >= r24_rel) &&
                      (s1_item_reg.rail24_b >= r24_rel);
        r5_fire     = (rail5_min_reg != 16'd0) && !cur.rail5 &&
                      ((s1_item_reg.rail5_a < rail5_min_reg) ||
                       (s1_item_reg.rail5_b < rail5_min_reg));
        r5_release  = (s1_item_reg.rail5_a >= r5_rel) &&
                      (s1_item_reg.rail5_b >= r5_rel);

        // next latch word
        if (cur.volt)
        begin
            wr_data.volt = !volt_release;
        end
        else
        begin
            wr_data.volt = volt_lo_hit || volt_hi_hit;
        end
        if (cur.freq)
        begin
            wr_data.freq = !freq_release;
        end
        else
        begin
            wr_data.freq = freq_lo_hit || freq_hi_hit;
        end
        if (r24_fire)
        begin
            wr_data.rail24 = 1'b1;
        end
        else
        begin
            wr_data.rail24 = cur.rail24 && !r24_release;
        end
        if (r5_fire)
        begin
            wr_data.rail5 = 1'b1;
        end
        else
        begin
            wr_data.rail5 = cur.rail5 && !r5_release;
        end

        if (s1_active)
        begin
            ev_mask = {r5_fire, r24_fire, freq_lo_hit || freq_hi_hit,
                       volt_lo_hit || volt_hi_hit};
        end
        else
        begin
            ev_mask = 4'b0000;
        end
    end

    // ------------------------------------------------------------------
    // Event buffer: holds one checked transfer while its events drain
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_mask_next = buf_mask_reg;
        if (s1_adv)
        begin
            buf_mask_next = ev_mask;
        end
        else if (evt_load)
        begin
            buf_mask_next = remain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_mask_reg <= 4'b0000;
        end
        else
        begin
            buf_mask_reg <= buf_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            buf_item_reg      <= s1_item_reg;
            buf_volt_code_reg <= volt_lo_hit ? FAULT_VOLT_LOW : FAULT_VOLT_HIGH;
            buf_freq_code_reg <= freq_lo_hit ? FAULT_FREQ_LOW : FAULT_FREQ_HIGH;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        evt_next.fault_unit  = buf_item_reg.unit;
        evt_next.fault_stamp = buf_item_reg.stamp;
        evt_next.last_event  = (remain == 4'b0000);
        if (pick[0])
        begin
            evt_next.fault_code  = buf_volt_code_reg;
            evt_next.fault_param = {16'd0, buf_item_reg.line_volt};
        end
        else if (pick[1])
        begin
            evt_next.fault_code  = buf_freq_code_reg;
            evt_next.fault_param = {16'd0, buf_item_reg.line_freq};
        end
        else if (pick[2])
        begin
            evt_next.fault_code  = FAULT_RAIL24;
            evt_next.fault_param = {buf_item_reg.rail24_b, buf_item_reg.rail24_a};
        end
        else
        begin
            evt_next.fault_code  = FAULT_RAIL5;
            evt_next.fault_param = {buf_item_reg.rail5_b, buf_item_reg.rail5_a};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            evt_valid_reg <= evt_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_load)
        begin
            evt_reg <= evt_next;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

/* sim/supply_window_fault_monitor_tb.sv */
// Self-checking testbench for the supply window fault monitor.
module supply_window_fault_monitor_tb
    import swfm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The timeout leaves a wide margin over the slowest correct run.
    localparam int unsigned TIMEOUT_NS    = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 6;    // pipeline settle after the last event
    localparam int unsigned LONG_HOLD     = 60;   // receiver hold-off under pressure
    localparam int          UNTYPED       = -1;   // directed row checked by predictor only
    localparam int          DIRECTED_ROWS = 23;

    logic         clk;
    logic         rst_n;
    logic         tlm_valid;
    logic         tlm_stall;
    telemetry_t   tlm;
    logic         evt_valid;
    logic         evt_stall;
    fault_event_t evt;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    supply_window_fault_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tlm_valid (tlm_valid),
        .tlm_stall (tlm_stall),
        .tlm       (tlm),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: register file and per-unit fault latches.
    // ------------------------------------------------------------------
    logic [15:0] limits [8];
    logic        volt_lat   [UNIT_COUNT];
    logic        freq_lat   [UNIT_COUNT];
    logic        rail24_lat [UNIT_COUNT];
    logic        rail5_lat  [UNIT_COUNT];

    // Fault events predicted but not yet seen on the output, oldest first.
    fault_event_t pending_faults [$];
    fault_event_t want_fault;
    int unsigned  mismatches;

    // Traffic shaping, shared by the sender and the receiver.
    bit          sender_quiet;
    bit          receiver_quiet;
    int unsigned long_hold_cycles;

    // Directed stimulus. A row with n_faults other than UNTYPED carries the
    // fault codes read off by hand, first event in the top three bits.
    typedef struct {
        logic [3:0]  unit;
        logic        alive;
        logic [15:0] volt;
        logic [15:0] freq;
        logic [15:0] r24a;
        logic [15:0] r24b;
        logic [15:0] r5a;
        logic [15:0] r5b;
        logic [31:0] stamp;
        int          n_faults;
        logic [11:0] codes;
    } directed_row_t;

    // Reset settings: volt window 241..364 (release 255..350), freq 95..105,
    // 24 V rail min 20 (release 22), 5 V rail min 4 (release 6).
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // nominal reading, nothing raised
        '{4'd0, 1'b1, 16'd300, 16'd100, 16'd100, 16'd100, 16'd50, 16'd50, 32'd0,
          0, 12'd0},
        // voltage at zero trips the low fault
        '{4'd0, 1'b1, 16'd0, 16'd100, 16'd100, 16'd100, 16'd50, 16'd50, 32'd1,
          1, {FAULT_VOLT_LOW, 9'd0}},
        // inside the window but under the release point: latch holds
        '{4'd0, 1'b1, 16'd250, 16'd100, 16'd100, 16'd100, 16'd50, 16'd50, 32'd2,
          0, 12'd0},
        // exactly at lower + hysteresis: latch releases
        '{4'd0, 1'b1, 16'd255, 16'd100, 16'd100, 16'd100, 16'd50, 16'd50, 32'd3,
          0, 12'd0},
        // everything at the extremes: all four faults
        '{4'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
          32'hFFFF_FFFF, 4, {FAULT_VOLT_HIGH, FAULT_FREQ_HIGH, FAULT_RAIL24, FAULT_RAIL5}},
        // same again: all latched, no repeat
        '{4'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
          32'd5, 0, 12'd0},
        // back to nominal: every latch of unit 0 releases
        '{4'd0, 1'b1, 16'd300, 16'd100, 16'd100, 16'd100, 16'd50, 16'd50, 32'd6,
          0, 12'd0},
        // released latches trip again
        '{4'd0, 1'b1, 16'd400, 16'd94, 16'd100, 16'd100, 16'd50, 16'd50, 32'd7,
          2, {FAULT_VOLT_HIGH, FAULT_FREQ_LOW, 6'd0}},
        '{4'd1, 1'b1, 16'd300, 16'd0, 16'd100, 16'd100, 16'd50, 16'd50, 32'd8,
          1, {FAULT_FREQ_LOW, 9'd0}},
        // unit not alive: skipped
        '{4'd2, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd9,
          0, 12'd0},
        // unit index out of range: ignored
        '{4'd15, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd10,
          0, 12'd0},
        '{4'd4, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd11,
          0, 12'd0},
        // one rail just under the minimum
        '{4'd3, 1'b1, 16'd300, 16'd100, 16'd19, 16'hFFFF, 16'd50, 16'd50, 32'd12,
          1, {FAULT_RAIL24, 9'd0}},
        // above the minimum but short of the release margin
        '{4'd3, 1'b1, 16'd300, 16'd100, 16'd21, 16'd21, 16'd50, 16'd50, 32'd13,
          0, 12'd0},
        '{4'd3, 1'b1, 16'd300, 16'd100, 16'd22, 16'd22, 16'd50, 16'd50, 32'd14,
          0, 12'd0},
        '{4'd3, 1'b1, 16'd300, 16'd100, 16'hFFFF, 16'd19, 16'd50, 16'd50, 32'd15,
          1, {FAULT_RAIL24, 9'd0}},
        '{4'd3, 1'b1, 16'd300, 16'd100, 16'd100, 16'd100, 16'd4, 16'd3, 32'd16,
          1, {FAULT_RAIL5, 9'd0}},
        // bounds themselves are inside; frequency latch of unit 1 releases
        '{4'd1, 1'b1, 16'd241, 16'd105, 16'd100, 16'd100, 16'd50, 16'd50, 32'd17,
          0, 12'd0},
        '{4'd1, 1'b1, 16'd240, 16'd106, 16'd100, 16'd100, 16'd50, 16'd50, 32'd18,
          2, {FAULT_VOLT_LOW, FAULT_FREQ_HIGH, 6'd0}},
        '{4'd1, 1'b1, 16'd364, 16'd95, 16'd20, 16'd20, 16'd4, 16'd4, 32'd19,
          0, 12'd0},
        '{4'd2, 1'b1, 16'd365, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF,
          3, {FAULT_VOLT_HIGH, FAULT_RAIL24, FAULT_RAIL5, 3'd0}},
        // alternating bit patterns
        '{4'd2, 1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
          32'h5555_AAAA, UNTYPED, 12'd0},
        '{4'd2, 1'b1, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
          32'hAAAA_5555, UNTYPED, 12'd0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Window comparator with release hysteresis; returns 1 when a fault is raised.
    function automatic bit window_trip(inout logic latched,
                                       input logic [15:0] v, lo, hi, hyst,
                                       input logic [2:0] lo_code, hi_code,
                                       output logic [2:0] code);
        logic [15:0] rel_lo;
        logic [15:0] rel_hi;
        rel_lo = lo + hyst;     // both wrap at 16 bits
        rel_hi = hi - hyst;
        code   = lo_code;
        if (!latched)
        begin
            if (lo != 16'd0 && v < lo)
            begin
                latched = 1'b1;
                return 1'b1;
            end
            if (hi != 16'd0 && v > hi)
            begin
                code    = hi_code;
                latched = 1'b1;
                return 1'b1;
            end
        end
        else if (v >= rel_lo && v <= rel_hi)
        begin
            latched = 1'b0;
        end
        return 1'b0;
    endfunction

    // Rail pair check; release is tried whenever no fault is raised.
    function automatic bit rail_trip(inout logic latched, input logic [15:0] a, b, mn);
        logic [15:0] rel;
        rel = mn + RAIL_MARGIN;
        if (mn != 16'd0 && !latched && (a < mn || b < mn))
        begin
            latched = 1'b1;
            return 1'b1;
        end
        if (a >= rel && b >= rel)
            latched = 1'b0;
        return 1'b0;
    endfunction

    function automatic fault_event_t make_fault(input logic [2:0] code,
                                                input telemetry_t item,
                                                input logic [31:0] param);
        fault_event_t f;
        f.fault_code  = code;
        f.fault_unit  = item.unit;
        f.fault_stamp = item.stamp;
        f.fault_param = param;
        f.last_event  = 1'b0;
        return f;
    endfunction

    // Updates the shadow latches for one telemetry transfer and returns the
    // fault events it raises, in output order.
    function automatic int predict_faults(input telemetry_t item,
                                          output fault_event_t evs [4]);
        int          n;
        int          k;
        logic [2:0]  code;
        n = 0;
        for (k = 0; k < 4; k++)
            evs[k] = '0;
        if (!item.alive || item.unit >= UNIT_COUNT)
            return 0;
        if (window_trip(volt_lat[item.unit], item.line_volt,
                        limits[CFG_LINE_VOLT_LOWER], limits[CFG_LINE_VOLT_UPPER],
                        limits[CFG_LINE_VOLT_HYST], FAULT_VOLT_LOW, FAULT_VOLT_HIGH, code))
        begin
            evs[n] = make_fault(code, item, {16'd0, item.line_volt});
            n++;
        end
        // frequency window has no hysteresis
        if (window_trip(freq_lat[item.unit], item.line_freq,
                        limits[CFG_FREQ_LOWER], limits[CFG_FREQ_UPPER], 16'd0,
                        FAULT_FREQ_LOW, FAULT_FREQ_HIGH, code))
        begin
            evs[n] = make_fault(code, item, {16'd0, item.line_freq});
            n++;
        end
        if (rail_trip(rail24_lat[item.unit], item.rail24_a, item.rail24_b,
                      limits[CFG_RAIL24_MIN]))
        begin
            evs[n] = make_fault(FAULT_RAIL24, item, {item.rail24_b, item.rail24_a});
            n++;
        end
        if (rail_trip(rail5_lat[item.unit], item.rail5_a, item.rail5_b,
                      limits[CFG_RAIL5_MIN]))
        begin
            evs[n] = make_fault(FAULT_RAIL5, item, {item.rail5_b, item.rail5_a});
            n++;
        end
        if (n > 0)
            evs[n-1].last_event = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Random telemetry, aimed at the current thresholds
    // ------------------------------------------------------------------
    function automatic logic [15:0] near(input logic [15:0] base);
        return base + 16'($urandom_range(0, 6)) - 16'd3;
    endfunction

    function automatic logic [15:0] draw_window(input logic [15:0] lo, hi, hyst);
        case ($urandom_range(0, 5))
            0: return near(lo);
            1: return near(lo + hyst);
            2: return near(hi);
            3: return near(hi - hyst);
            4: return (lo >> 1) + (hi >> 1);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] draw_rail(input logic [15:0] mn);
        case ($urandom_range(0, 3))
            0: return near(mn);
            1: return near(mn + RAIL_MARGIN);
            2: return mn + 16'($urandom_range(0, 200));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic telemetry_t draw_telemetry();
        telemetry_t item;
        // mostly units the block tracks, so latches see repeated traffic
        if ($urandom_range(0, 9) == 0)
            item.unit = 4'($urandom());
        else
            item.unit = 4'($urandom_range(0, UNIT_COUNT - 1));
        item.alive     = ($urandom_range(0, 7) != 0);
        item.line_volt = draw_window(limits[CFG_LINE_VOLT_LOWER],
                                     limits[CFG_LINE_VOLT_UPPER],
                                     limits[CFG_LINE_VOLT_HYST]);
        item.line_freq = draw_window(limits[CFG_FREQ_LOWER], limits[CFG_FREQ_UPPER], 16'd0);
        item.rail24_a  = draw_rail(limits[CFG_RAIL24_MIN]);
        item.rail24_b  = draw_rail(limits[CFG_RAIL24_MIN]);
        item.rail5_a   = draw_rail(limits[CFG_RAIL5_MIN]);
        item.rail5_b   = draw_rail(limits[CFG_RAIL5_MIN]);
        item.stamp     = $urandom();
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Sender side: telemetry and configuration
    // ------------------------------------------------------------------

    // Predicts the transfer, queues its events, then offers it after a random
    // gap. Valid stays high on return so back-to-back transfers need no bubble.
    task automatic offer_telemetry(input telemetry_t item, output int n,
                                   output fault_event_t evs [4]);
        int unsigned gap;
        int          k;
        n = predict_faults(item, evs);
        for (k = 0; k < n; k++)
            pending_faults.push_back(evs[k]);
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            tlm_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tlm_valid <= 1'b1;
        tlm       <= item;
        do
            @(posedge clk);
        while (tlm_stall);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned  i;
        int           n;
        fault_event_t evs [4];
        for (i = 0; i < count; i++)
        begin
            // change the traffic shape every few transfers
            if (i != 0 && i % 16 == 0)
            begin
                sender_quiet   = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            offer_telemetry(draw_telemetry(), n, evs);
        end
    endtask

    // Drop valid and wait until every predicted event has drained, then let
    // the pipeline settle so a trailing skipped transfer has retired too.
    task automatic wait_idle();
        tlm_valid <= 1'b0;
        while (pending_faults.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all seven registers back to back; only called while idle.
    task automatic load_limits(input logic [15:0] vals [8]);
        int idx;
        for (idx = CFG_LINE_VOLT_LOWER; idx <= CFG_RAIL5_MIN; idx++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(idx);
            cfg_data  <= vals[idx];
            do
                @(posedge clk);
            while (!cfg_ready);
            limits[idx] = vals[idx];
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: draws a stall before each event, or takes a long hold-off
    // when one is requested, counted here in its own cycles.
    // ------------------------------------------------------------------
    initial
    begin : event_sink
        int unsigned hold;
        evt_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_cycles != 0)
            begin
                hold             = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
            begin
                hold = receiver_quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold != 0)
            begin
                evt_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                evt_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(rst_n && evt_valid));
        end
    end

    // ------------------------------------------------------------------
    // Output checker: every accepted event against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_faults.size() == 0)
            begin
                $error("fault event with nothing pending: code %0d unit %0d stamp %h",
                       evt.fault_code, evt.fault_unit, evt.fault_stamp);
                mismatches++;
            end
            else
            begin
                want_fault = pending_faults.pop_front();
                if (evt.fault_code !== want_fault.fault_code)
                begin
                    $error("fault_code: expected %0d, got %0d",
                           want_fault.fault_code, evt.fault_code);
                    mismatches++;
                end
                if (evt.fault_unit !== want_fault.fault_unit)
                begin
                    $error("fault_unit: expected %0d, got %0d",
                           want_fault.fault_unit, evt.fault_unit);
                    mismatches++;
                end
                if (evt.fault_stamp !== want_fault.fault_stamp)
                begin
                    $error("fault_stamp: expected %h, got %h",
                           want_fault.fault_stamp, evt.fault_stamp);
                    mismatches++;
                end
                if (evt.fault_param !== want_fault.fault_param)
                begin
                    $error("fault_param: expected %h, got %h",
                           want_fault.fault_param, evt.fault_param);
                    mismatches++;
                end
                if (evt.last_event !== want_fault.last_event)
                begin
                    $error("last_event: expected %0b, got %0b",
                           want_fault.last_event, evt.last_event);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        directed_row_t row;
        telemetry_t    item;
        fault_event_t  evs [4];
        logic [15:0]   vals [8];
        int            n;
        int            r;
        int            k;
        int            u;

        // every input known from time zero; reset held before release
        rst_n     <= 1'b0;
        tlm_valid <= 1'b0;
        tlm       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mismatches       = 0;
        sender_quiet     = 1'b0;
        receiver_quiet   = 1'b0;
        long_hold_cycles = 0;

        // shadow state after reset
        limits[CFG_LINE_VOLT_LOWER] = RST_LINE_VOLT_LOWER;
        limits[CFG_LINE_VOLT_UPPER] = RST_LINE_VOLT_UPPER;
        limits[CFG_LINE_VOLT_HYST]  = RST_LINE_VOLT_HYST;
        limits[CFG_FREQ_LOWER]      = RST_FREQ_LOWER;
        limits[CFG_FREQ_UPPER]      = RST_FREQ_UPPER;
        limits[CFG_RAIL24_MIN]      = RST_RAIL24_MIN;
        limits[CFG_RAIL5_MIN]       = RST_RAIL5_MIN;
        limits[7]                   = 16'd0;
        for (u = 0; u < UNIT_COUNT; u++)
        begin
            volt_lat[u]   = 1'b0;
            freq_lat[u]   = 1'b0;
            rail24_lat[u] = 1'b0;
            rail5_lat[u]  = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings. Hand-typed codes are
        // checked against the predictor; the block is checked against the
        // predictor by the output checker.
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row  = directed_rows[r];
            item = '{row.unit, row.alive, row.volt, row.freq, row.r24a, row.r24b,
                     row.r5a, row.r5b, row.stamp};
            offer_telemetry(item, n, evs);
            if (row.n_faults != UNTYPED)
            begin
                if (n != row.n_faults)
                begin
                    $error("row %0d fault count: expected %0d, got %0d",
                           r, row.n_faults, n);
                    mismatches++;
                end
                else
                begin
                    for (k = 0; k < n; k++)
                    begin
                        if (evs[k].fault_code != row.codes[11 - 3*k -: 3])
                        begin
                            $error("row %0d fault_code %0d: expected %0d, got %0d",
                                   r, k, row.codes[11 - 3*k -: 3], evs[k].fault_code);
                            mismatches++;
                        end
                    end
                end
            end
        end
        run_random(25);
        wait_idle();

        // Every bound zero: nothing can trip, latches left over only release.
        for (k = 0; k < 8; k++)
            vals[k] = 16'h0000;
        load_limits(vals);
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b0;
        run_random(15);
        wait_idle();

        // Every bound at full scale: low faults on almost anything, the volt
        // release window is empty and the rail release margin wraps to 1.
        for (k = 0; k < 8; k++)
            vals[k] = 16'hFFFF;
        load_limits(vals);
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b1;
        run_random(20);
        wait_idle();

        // Plausible random windows with modest hysteresis.
        vals[CFG_LINE_VOLT_LOWER] = 16'($urandom_range(1, 40000));
        vals[CFG_LINE_VOLT_UPPER] = vals[CFG_LINE_VOLT_LOWER] + 16'($urandom_range(0, 20000));
        vals[CFG_LINE_VOLT_HYST]  = 16'($urandom_range(0, 40));
        vals[CFG_FREQ_LOWER]      = 16'($urandom_range(1, 40000));
        vals[CFG_FREQ_UPPER]      = vals[CFG_FREQ_LOWER] + 16'($urandom_range(0, 20000));
        vals[CFG_RAIL24_MIN]      = 16'($urandom_range(1, 1000));
        vals[CFG_RAIL5_MIN]       = 16'($urandom_range(1, 1000));
        load_limits(vals);
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        run_random(35);
        wait_idle();

        // Anything goes: inverted windows and wrapping release points.
        for (k = CFG_LINE_VOLT_LOWER; k <= CFG_RAIL5_MIN; k++)
            vals[k] = 16'($urandom());
        load_limits(vals);
        run_random(25);
        wait_idle();

        // Back to reset settings under pressure: the receiver holds off for
        // a long stretch while telemetry keeps coming with no gaps, so the
        // block backs up and stalls its input.
        vals[CFG_LINE_VOLT_LOWER] = RST_LINE_VOLT_LOWER;
        vals[CFG_LINE_VOLT_UPPER] = RST_LINE_VOLT_UPPER;
        vals[CFG_LINE_VOLT_HYST]  = RST_LINE_VOLT_HYST;
        vals[CFG_FREQ_LOWER]      = RST_FREQ_LOWER;
        vals[CFG_FREQ_UPPER]      = RST_FREQ_UPPER;
        vals[CFG_RAIL24_MIN]      = RST_RAIL24_MIN;
        vals[CFG_RAIL5_MIN]       = RST_RAIL5_MIN;
        load_limits(vals);
        sender_quiet     = 1'b1;
        receiver_quiet   = 1'b0;
        long_hold_cycles = LONG_HOLD;
        run_random(25);
        wait_idle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
